@@ rtl/kms_pkg.sv @@
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and constants for the keyframe matrix sampler.
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int MAX_KEYS     = 16;
    localparam int MATRIX_ELEMS = 16;
    localparam int KEY_W        = $clog2(MAX_KEYS);
    localparam int ELEM_W       = $clog2(MATRIX_ELEMS);
    localparam int MAT_AW       = KEY_W + ELEM_W;

    // command codes
    localparam logic [1:0] CMD_EVAL  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_LOAD  = 2'd3;

    // animation modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ONCE = 2'd1;
    localparam logic [1:0] MODE_LOOP = 2'd2;

    // load targets beyond the matrix elements
    localparam logic [4:0] ELEM_TIME = 5'd16;
    localparam logic [4:0] ELEM_KIND = 5'd17;

    // register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_SPEED     = 2'd1;
    localparam logic [1:0] REG_TICK_RATE = 2'd2;
    localparam logic [1:0] REG_KEY_COUNT = 2'd3;

    localparam logic [31:0] TIME_MAX = 32'h7FFF_FFFF;

    // divider sizes
    localparam int DIVQ_W     = 56;
    localparam int TDIV_STEPS = 56;
    localparam int FDIV_STEPS = 16;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        delta_ticks;
        logic [3:0]         key_index;
        logic [4:0]         element_index;
        logic signed [31:0] load_value;
    } item_t;

    typedef struct packed {
        logic [3:0]         element_index_out;
        logic signed [31:0] element_value;
        logic               interpolated;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0]  anim_mode;
        logic [15:0] speed;
        logic [19:0] tick_rate;
        logic [4:0]  key_count;
    } cfg_t;

    typedef struct packed {
        logic              timer_start;
        logic              timer_stop;
        logic              load_wr;
        logic              eval_init;
        logic              mul_ld;
        logic              tdiv_ld;
        logic              div_step;
        logic              t_ld;
        logic              key_rd;
        logic              scan_shift;
        logic              fdiv_ld;
        logic              lerp_rd;
        logic              lerp_mul;
        logic              emit_elem;
        logic              emit_inv;
        logic              end_act;
        logic [KEY_W-1:0]  key_sel;
        logic [ELEM_W-1:0] elem_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic running;
        logic seg_hit;
    } dp_stat_t;

endpackage

@@ rtl/kms_ctrl.sv @@
// ----------------------------------------------------------------------------
// kms_ctrl
// Sequencer: timer divide, segment scan, factor divide and element lerps.
// ----------------------------------------------------------------------------
module kms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  kms_pkg::item_t   item,
    input  kms_pkg::cfg_t    cfg,
    input  kms_pkg::dp_stat_t stat,
    output kms_pkg::dp_cmd_t cmd,
    output logic             busy
);
    import kms_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_TLD    = 4'd2;
    localparam logic [3:0] S_TDIV   = 4'd3;
    localparam logic [3:0] S_TSET   = 4'd4;
    localparam logic [3:0] S_SCAN_A = 4'd5;
    localparam logic [3:0] S_SCAN_D = 4'd6;
    localparam logic [3:0] S_END    = 4'd7;
    localparam logic [3:0] S_FDIV   = 4'd8;
    localparam logic [3:0] S_LERP_A = 4'd9;
    localparam logic [3:0] S_LERP_M = 4'd10;
    localparam logic [3:0] S_LERP_O = 4'd11;

    localparam int CNT_W = $clog2(TDIV_STEPS);

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [KEY_W-1:0]  last_key;

    // last key in use: count clamped to 1..MAX_KEYS
    always_comb
    begin
        if (32'(cfg.key_count) > MAX_KEYS)
            last_key = KEY_W'(MAX_KEYS - 1);
        else if (cfg.key_count == 5'd0)
            last_key = '0;
        else
            last_key = KEY_W'(cfg.key_count - 5'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            key_reg   <= '0;
            elem_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            key_reg   <= key_next;
            elem_reg  <= elem_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        elem_next  = elem_reg;
        cmd        = '0;
        cmd.key_sel  = key_reg;
        cmd.elem_sel = elem_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.command)
                        CMD_START: cmd.timer_start = 1'b1;
                        CMD_STOP:  cmd.timer_stop  = 1'b1;
                        CMD_LOAD:  cmd.load_wr     = 1'b1;
                        default:
                        begin
                            if (cfg.anim_mode == MODE_ONCE && !stat.running)
                                cmd.emit_inv = 1'b1;
                            else
                            begin
                                cmd.eval_init = 1'b1;
                                state_next    = S_MUL;
                            end
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul_ld = 1'b1;
                state_next = S_TLD;
            end
            S_TLD:
            begin
                cmd.tdiv_ld = 1'b1;
                cnt_next    = '0;
                state_next  = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TDIV_STEPS - 1))
                    state_next = S_TSET;
            end
            S_TSET:
            begin
                cmd.t_ld   = 1'b1;
                key_next   = '0;
                state_next = S_SCAN_A;
            end
            S_SCAN_A:
            begin
                cmd.key_rd = 1'b1;
                state_next = S_SCAN_D;
            end
            S_SCAN_D:
            begin
                if (key_reg != '0 && stat.seg_hit)
                begin
                    cmd.fdiv_ld = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_FDIV;
                end
                else if (key_reg == last_key)
                    state_next = S_END;
                else
                begin
                    cmd.scan_shift = 1'b1;
                    key_next       = key_reg + 1'b1;
                    state_next     = S_SCAN_A;
                end
            end
            S_END:
            begin
                cmd.end_act  = 1'b1;
                cmd.emit_inv = 1'b1;
                state_next   = S_IDLE;
            end
            S_FDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FDIV_STEPS - 1))
                begin
                    elem_next  = '0;
                    state_next = S_LERP_A;
                end
            end
            S_LERP_A:
            begin
                cmd.lerp_rd = 1'b1;
                state_next  = S_LERP_M;
            end
            S_LERP_M:
            begin
                cmd.lerp_mul = 1'b1;
                state_next   = S_LERP_O;
            end
            S_LERP_O:
            begin
                cmd.emit_elem = 1'b1;
                elem_next     = elem_reg + 1'b1;
                if (elem_reg == ELEM_W'(MATRIX_ELEMS - 1))
                    state_next = S_IDLE;
                else
                    state_next = S_LERP_A;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // a scan never runs past the last key in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_D |-> key_reg <= last_key)
        else $error("segment scan beyond last key");

    // element lerps end only after the final element
    a_lerp_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LERP_O && elem_reg == ELEM_W'(MATRIX_ELEMS - 1) |=> state_reg == S_IDLE)
        else $error("lerp sequence did not finish");

    // one emission at most per cycle
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_elem && cmd.emit_inv))
        else $error("two emissions in one cycle");

endmodule

@@ rtl/kms_dp.sv @@
// ----------------------------------------------------------------------------
// kms_dp
// Datapath: timer, key stores, shift-subtract divider, lerp multiplier and
// result register.
// ----------------------------------------------------------------------------
module kms_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  kms_pkg::item_t    item,
    input  kms_pkg::cfg_t     cfg,
    input  kms_pkg::dp_cmd_t  cmd,
    output kms_pkg::dp_stat_t stat,
    output kms_pkg::result_t  result,
    output logic              result_valid
);
    import kms_pkg::*;

    // stores
    logic [31:0] key_times [MAX_KEYS];
    logic [31:0] key_mat   [MAX_KEYS * MATRIX_ELEMS];
    logic        key_lin   [MAX_KEYS];

    logic        running_reg, running_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [47:0] prod_reg;
    logic [32:0] div_rem_reg;
    logic [DIVQ_W-1:0] div_quo_reg;
    logic [33:0] div_den_reg;
    logic [31:0] t_reg;
    logic [31:0] cur_time_reg;
    logic        cur_lin_reg;
    logic [31:0] prev_time_reg;
    logic        prev_lin_reg;
    logic [31:0] mat_a_reg, mat_b_reg;
    logic [49:0] lerp_prod_reg;
    result_t     result_reg;
    logic        result_valid_reg;

    logic [32:0] sum_elapsed;
    logic [31:0] base_elapsed;
    logic        run_eff;
    logic [33:0] div_shift;
    logic [34:0] div_trial;
    logic [32:0] t_ext, prev_ext, cur_ext;
    logic [KEY_W-1:0]  key_a;
    logic [MAT_AW-1:0] load_addr;
    logic signed [32:0] lerp_diff;
    logic [33:0] lerp_sum;
    logic        end_ge;

    // key stores: written by load, read into registers (the matrix store gives two elements per read)
    assign load_addr = {KEY_W'(item.key_index), item.element_index[ELEM_W-1:0]};
    assign key_a     = cmd.key_sel - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && 32'(item.key_index) < MAX_KEYS)
        begin
            if (32'(item.element_index) < MATRIX_ELEMS)
                key_mat[load_addr] <= item.load_value;
            else if (item.element_index == ELEM_TIME)
                key_times[KEY_W'(item.key_index)] <= item.load_value;
            else if (item.element_index == ELEM_KIND)
                key_lin[KEY_W'(item.key_index)] <= (item.load_value == 32'sd0);
        end
        if (cmd.key_rd)
        begin
            cur_time_reg <= key_times[cmd.key_sel];
            cur_lin_reg  <= key_lin[cmd.key_sel];
        end
        if (cmd.lerp_rd)
        begin
            mat_a_reg <= key_mat[{key_a, cmd.elem_sel}];
            mat_b_reg <= key_mat[{cmd.key_sel, cmd.elem_sel}];
        end
    end

    // timer
    assign run_eff      = running_reg || (cfg.anim_mode == MODE_LOOP);
    assign base_elapsed = running_reg ? elapsed_reg : 32'd0;
    assign sum_elapsed  = {1'b0, base_elapsed} + {17'd0, item.delta_ticks};

    always_comb
    begin
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        if (cmd.timer_start && !running_reg)
        begin
            running_next = 1'b1;
            elapsed_next = '0;
        end
        if (cmd.timer_stop)
        begin
            running_next = 1'b0;
            elapsed_next = '0;
        end
        if (cmd.eval_init && run_eff)
        begin
            running_next = 1'b1;
            elapsed_next = sum_elapsed[32] ? 32'hFFFF_FFFF : sum_elapsed[31:0];
        end
        if (cmd.end_act && end_ge)
        begin
            if (cfg.anim_mode == MODE_LOOP)
            begin
                running_next = 1'b1;
                elapsed_next = '0;
            end
            else if (cfg.anim_mode == MODE_ONCE)
                running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // signed compares for the scan
    assign t_ext    = {t_reg[31], t_reg};
    assign prev_ext = {prev_time_reg[31], prev_time_reg};
    assign cur_ext  = {cur_time_reg[31], cur_time_reg};
    assign stat.running = running_reg;
    assign stat.seg_hit = prev_lin_reg && ($signed(t_ext) >= $signed(prev_ext))
                          && ($signed(t_ext) < $signed(cur_ext));
    assign end_ge = $signed(t_ext) >= $signed(cur_ext);

    // restoring divider step
    assign div_shift = {div_rem_reg, div_quo_reg[DIVQ_W-1]};
    assign div_trial = {1'b0, div_shift} - {1'b0, div_den_reg};

    // lerp: a + floor((b - a) * f / 2^16)
    assign lerp_diff = $signed({mat_b_reg[31], mat_b_reg}) - $signed({mat_a_reg[31], mat_a_reg});
    assign lerp_sum  = lerp_prod_reg[49:16] + {{2{mat_a_reg[31]}}, mat_a_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_ld)
            prod_reg <= elapsed_reg * cfg.speed;
        if (cmd.tdiv_ld)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= {prod_reg, 8'd0};
            div_den_reg <= {14'd0, cfg.tick_rate};
        end
        else if (cmd.fdiv_ld)
        begin
            div_rem_reg <= t_ext - prev_ext;
            div_quo_reg <= '0;
            div_den_reg <= {1'b0, cur_ext - prev_ext};
        end
        else if (cmd.div_step)
        begin
            if (!div_trial[34])
            begin
                div_rem_reg <= div_trial[32:0];
                div_quo_reg <= {div_quo_reg[DIVQ_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_shift[32:0];
                div_quo_reg <= {div_quo_reg[DIVQ_W-2:0], 1'b0};
            end
        end
        if (cmd.t_ld)
        begin
            if (cfg.tick_rate == 20'd0 || (|div_quo_reg[DIVQ_W-1:31]))
                t_reg <= TIME_MAX;
            else
                t_reg <= div_quo_reg[31:0];
        end
        if (cmd.scan_shift)
        begin
            prev_time_reg <= cur_time_reg;
            prev_lin_reg  <= cur_lin_reg;
        end
        if (cmd.lerp_mul)
            lerp_prod_reg <= 50'($signed(lerp_diff) * $signed({1'b0, div_quo_reg[15:0]}));
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_elem)
        begin
            result_reg.element_index_out <= 4'(cmd.elem_sel);
            result_reg.element_value     <= lerp_sum[31:0];
            result_reg.interpolated      <= 1'b1;
            result_reg.last              <= (cmd.elem_sel == ELEM_W'(MATRIX_ELEMS - 1));
        end
        else if (cmd.emit_inv)
        begin
            result_reg.element_index_out <= '0;
            result_reg.element_value     <= '0;
            result_reg.interpolated      <= 1'b0;
            result_reg.last              <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= cmd.emit_elem || cmd.emit_inv;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ rtl/keyframe_matrix_sampler_core.sv @@
// ----------------------------------------------------------------------------
// keyframe_matrix_sampler_core
// Keyframe matrix sampler: APB registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Timer, stop and load requests are acted on in idle and leave it idle.
// An evaluate runs a 56-step time divide and a key scan, one key at a time,
// then gives one invalid result, or a 16-step factor divide and 16 results.
// In once mode with the timer stopped, an evaluate gives the invalid result only.
// The receiver cannot stall; each result is shown for one cycle.
// Reset (rst_n, asynchronous) stops the timer and loads register defaults;
// key stores are undefined until loaded.
module keyframe_matrix_sampler_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kms_pkg::item_t   item,
    output kms_pkg::result_t result,
    output logic             result_valid,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import kms_pkg::*;

    cfg_t      cfg_reg;
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.anim_mode <= MODE_NONE;
            cfg_reg.speed     <= 16'd256;
            cfg_reg.tick_rate <= 20'd1000;
            cfg_reg.key_count <= 5'd2;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MODE:      cfg_reg.anim_mode <= pwdata[1:0];
                REG_SPEED:     cfg_reg.speed     <= pwdata[15:0];
                REG_TICK_RATE: cfg_reg.tick_rate <= pwdata[19:0];
                REG_KEY_COUNT: cfg_reg.key_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:      prdata = {30'd0, cfg_reg.anim_mode};
            REG_SPEED:     prdata = {16'd0, cfg_reg.speed};
            REG_TICK_RATE: prdata = {12'd0, cfg_reg.tick_rate};
            REG_KEY_COUNT: prdata = {27'd0, cfg_reg.key_count};
            default:       prdata = '0;
        endcase
    end

    kms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .cfg   (cfg_reg),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    kms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

    // an invalid result always closes its evaluate
    a_inv_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.interpolated |-> result.last)
        else $error("invalid result not marked last");

    // an invalid result carries zeros
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.interpolated |->
            result.element_index_out == 4'd0 && result.element_value == 32'sd0)
        else $error("invalid result carries data");

    // non-evaluate requests give no result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command != CMD_EVAL |=> !result_valid)
        else $error("result after non-evaluate request");

endmodule
